// ===== src/knn_pkg.sv =====
// Shared types, operation codes and widths for the k-nearest-neighbor search block.
`timescale 1ns / 1ps
package knn_pkg;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_REF    = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  localparam logic [1:0] CFG_POINT_COUNT    = 2'd0;
  localparam logic [1:0] CFG_DIM_COUNT      = 2'd1;
  localparam logic [1:0] CFG_NEIGHBOR_COUNT = 2'd2;

  localparam int DIST_W = 48;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Candidate passed down the sorting chain.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sq_dist;
    logic [15:0]       idx;
  } cand_t;
endpackage

// ===== src/knn_cell.sv =====
// One cell of the sorting chain: keeps one best candidate and passes the loser on.
`timescale 1ns / 1ps
module knn_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear,
  input  knn_pkg::cand_t cand_in,
  output knn_pkg::cand_t cand_out,
  output knn_pkg::cand_t held
);
  knn_pkg::cand_t held_r, held_nxt, out_r, out_nxt;
  logic take;

  // Candidates can reach a cell out of index order, so equal distances are
  // decided by the index; an empty cell takes any valid candidate.
  assign take = cand_in.valid && (!held_r.valid || (cand_in.sq_dist < held_r.sq_dist) ||
                ((cand_in.sq_dist == held_r.sq_dist) && (cand_in.idx < held_r.idx)));

  always_comb begin
    held_nxt = held_r;
    out_nxt  = cand_in;
    if (take) begin
      held_nxt = cand_in;
      out_nxt  = held_r;
    end
    if (clear) begin
      held_nxt = '0;
      out_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      out_r  <= '0;
    end else begin
      held_r <= held_nxt;
      out_r  <= out_nxt;
    end
  end

  assign cand_out = out_r;
  assign held     = held_r;
endmodule

// ===== src/knn_isqrt.sv =====
// Iterative integer square root; a start while busy restarts it with the new radicand.
`timescale 1ns / 1ps
module knn_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] radicand,
  output logic        done,
  output logic [23:0] root
);
  logic [47:0] x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [47:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    x_nxt = x_r; res_nxt = res_r; bit_nxt = bit_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      x_nxt = radicand; res_nxt = '0; bit_nxt = 48'd1 << 46; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt   = x_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[23:0];
endmodule

// ===== src/knn_search_weighted_euclid.sv =====
// Top level of the weighted Euclidean k-nearest-neighbor search.
// A triggering query coordinate is followed by a multiply-accumulate over
// point_count * dim_count point dimensions (one reference read per cycle), a drain of
// the sorting chain, then a square root for each result.
// Only one query is in flight; no new transaction is taken until its results leave.
// Reset is synchronous active low: registers go to 1024, 16, 1; stores are not cleared.
`timescale 1ns / 1ps
module knn_search_weighted_euclid #(
  parameter int MAX_POINTS    = 1024,
  parameter int MAX_DIMS      = 16,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_point_index,
  input  logic [3:0]         in_dim_index,
  input  logic signed [15:0] in_coord_value,
  input  logic [15:0]        in_weight_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_rank,
  output logic [9:0]         out_neighbor_index,
  output logic [23:0]        out_distance,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int KW = $clog2(MAX_NEIGHBORS + 1);
  localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int AW = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int NCW = $clog2(MAX_POINTS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int DRAIN = MAX_NEIGHBORS + 4;
  localparam int DRW = $clog2(DRAIN + 1);

  localparam logic [2:0] ST_IDLE = 3'd0, ST_RUN = 3'd1, ST_DRAIN = 3'd2,
                         ST_SQRT = 3'd3, ST_WAIT = 3'd4, ST_OUT = 3'd5;

  logic [2:0] st_r, st_nxt;

  logic [10:0] pc_r; logic [4:0] dc_r, nc_r;
  assign cfg_ready = (st_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 11'd1024; dc_r <= 5'd16; nc_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        knn_pkg::CFG_POINT_COUNT:    pc_r <= cfg_data[10:0];
        knn_pkg::CFG_DIM_COUNT:      dc_r <= cfg_data[4:0];
        knn_pkg::CFG_NEIGHBOR_COUNT: nc_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [NCW-1:0] npts; logic [DCW-1:0] ndims; logic [KW-1:0] kk;
  always_comb begin
    npts = (pc_r == 0) ? NCW'(1) : ((32'(pc_r) > MAX_POINTS) ? NCW'(MAX_POINTS) : NCW'(pc_r));
    ndims = (dc_r == 0) ? DCW'(1) : ((32'(dc_r) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dc_r));
    kk = (nc_r == 0) ? KW'(1)
       : ((32'(nc_r) > MAX_NEIGHBORS) ? KW'(MAX_NEIGHBORS) : KW'(nc_r));
    if (32'(kk) > 32'(npts)) kk = KW'(npts);
  end

  logic [15:0] ref_mem [MAX_POINTS*MAX_DIMS];
  logic [15:0] w_r [MAX_DIMS];
  logic [15:0] q_r [MAX_DIMS];

  logic [PW-1:0] pi_r; logic [DW-1:0] di_r;
  logic [KW-1:0] k_r, oi_r;
  logic [DRW-1:0] dr_r;
  logic acc_tx;
  logic trig;
  assign acc_tx = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign trig = acc_tx && in_operation == knn_pkg::OP_QUERY &&
                32'(in_dim_index) == 32'(ndims) - 1;

  always_ff @(posedge clk) begin
    if (acc_tx) begin
      if (in_operation == knn_pkg::OP_LOAD_WEIGHT && 32'(in_dim_index) < MAX_DIMS)
        w_r[DW'(in_dim_index)] <= in_weight_value;
      if (in_operation == knn_pkg::OP_QUERY && 32'(in_dim_index) < MAX_DIMS)
        q_r[DW'(in_dim_index)] <= in_coord_value;
      if (in_operation == knn_pkg::OP_LOAD_REF && 32'(in_dim_index) < MAX_DIMS &&
          32'(in_point_index) < MAX_POINTS)
        ref_mem[AW'((32'(in_point_index) * MAX_DIMS) + 32'(in_dim_index))] <= in_coord_value;
    end
  end

  // Stage 1: registered memory read; stage 2: difference squared; stage 3: weighting.
  logic run_step, last_dim;
  assign run_step = (st_r == ST_RUN);
  assign last_dim = (32'(di_r) == 32'(ndims) - 1);
  logic [15:0] rd_r, qd_r, wd_r; logic v1_r, l1_r; logic [15:0] p1_r;
  logic [31:0] sq_r; logic [15:0] w2_r; logic v2_r, l2_r; logic [15:0] p2_r;
  logic [47:0] wp_r; logic v3_r, l3_r; logic [15:0] p3_r;
  logic [52:0] acc_r;
  knn_pkg::cand_t feed_r;
  logic signed [16:0] diff;
  logic [16:0] adiff;
  assign diff  = 17'(signed'(rd_r)) - 17'(signed'(qd_r));
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk) begin
    rd_r <= ref_mem[AW'((32'(pi_r) * MAX_DIMS) + 32'(di_r))];
    qd_r <= q_r[di_r]; wd_r <= w_r[di_r];
    l1_r <= last_dim; p1_r <= 16'(pi_r);
    sq_r <= 32'(adiff) * 32'(adiff); w2_r <= wd_r; l2_r <= l1_r; p2_r <= p1_r;
    wp_r <= 48'(sq_r) * 48'(w2_r);
    l3_r <= l2_r; p3_r <= p2_r;
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; acc_r <= '0; feed_r <= '0;
    end else begin
      v1_r <= run_step; v2_r <= v1_r; v3_r <= v2_r;
      feed_r.valid <= v3_r && l3_r;
      if (v3_r) begin
        if (l3_r) begin
          acc_r <= '0;
          feed_r.idx     <= p3_r;
          feed_r.sq_dist <= ((acc_r + 53'(wp_r)) >> 8) > 53'(knn_pkg::DIST_MAX)
                          ? knn_pkg::DIST_MAX : 48'((acc_r + 53'(wp_r)) >> 8);
        end else begin
          acc_r <= acc_r + 53'(wp_r);
        end
      end
    end
  end

  knn_pkg::cand_t chain [MAX_NEIGHBORS+1];
  knn_pkg::cand_t held  [MAX_NEIGHBORS];
  logic clr;
  assign clr = trig;
  assign chain[0] = feed_r;
  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
    knn_cell u_cell (.clk(clk), .rst_n(rst_n), .clear(clr), .cand_in(chain[g]),
                     .cand_out(chain[g+1]), .held(held[g]));
  end

  logic sq_start, sq_done; logic [23:0] root;
  knn_pkg::cand_t sel;
  assign sel = held[NW'(oi_r)];
  assign sq_start = (st_r == ST_SQRT);
  knn_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sel.sq_dist),
                    .done(sq_done), .root(root));

  logic ov_r; logic [3:0] rk_r; logic [9:0] ni_r; logic [23:0] dd_r; logic lst_r;
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (trig) st_nxt = ST_RUN;
      ST_RUN:   if (last_dim && 32'(pi_r) == 32'(npts) - 1) st_nxt = ST_DRAIN;
      ST_DRAIN: if (dr_r == DRW'(DRAIN)) st_nxt = ST_SQRT;
      ST_SQRT:  st_nxt = ST_WAIT;
      ST_WAIT:  if (sq_done) st_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) st_nxt = (oi_r == k_r - 1'b1) ? ST_IDLE : ST_SQRT;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; pi_r <= '0; di_r <= '0; dr_r <= '0; oi_r <= '0; k_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (trig) begin
        pi_r <= '0; di_r <= '0; dr_r <= '0; oi_r <= '0; k_r <= kk;
      end
      if (run_step) begin
        if (last_dim) begin
          di_r <= '0; pi_r <= pi_r + 1'b1;
        end else di_r <= di_r + 1'b1;
      end
      if (st_r == ST_DRAIN) dr_r <= dr_r + 1'b1;
      if (st_r == ST_WAIT && sq_done) ov_r <= 1'b1;
      if (st_r == ST_OUT && !out_stall) begin
        ov_r <= 1'b0; oi_r <= oi_r + 1'b1;
      end
    end
    if (st_r == ST_WAIT && sq_done) begin
      rk_r <= 4'(oi_r); ni_r <= 10'(sel.idx); dd_r <= root; lst_r <= (oi_r == k_r - 1'b1);
    end
  end

  assign out_valid = ov_r;
  assign out_rank = rk_r;
  assign out_neighbor_index = ni_r;
  assign out_distance = dd_r;
  assign out_last = lst_r;
endmodule

// ===== src/knn_checker.sv =====
// Port-level assertions for the k-nearest-neighbor search block.
`timescale 1ns / 1ps
module knn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_rank,
  input logic       out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rank)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid) else $error("result after last");
endmodule

bind knn_search_weighted_euclid knn_checker u_knn_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_rank(out_rank), .out_last(out_last));

// ===== test/knn_result_checker.sv =====
// Neighbor-list predictor and result checker for the weighted Euclidean k-NN search block.
`timescale 1ns / 1ps
module knn_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_point_index,
  input  logic [3:0]         in_dim_index,
  input  logic signed [15:0] in_coord_value,
  input  logic [15:0]        in_weight_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         out_rank,
  input  logic [9:0]         out_neighbor_index,
  input  logic [23:0]        out_distance,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  localparam int NPTS = 1024;
  localparam int NDIMS = 16;
  localparam int NNBR = 16;

  typedef struct packed {
    logic [3:0]  rank;
    logic [9:0]  index;
    logic [23:0] root_dist;
    logic        last;
  } neighbor_t;

  logic signed [15:0] ref_coord [NPTS][NDIMS];
  logic [15:0]        dim_weight [NDIMS];
  logic signed [15:0] query_coord [NDIMS];
  logic [10:0]        point_reg;
  logic [4:0]         dim_reg;
  logic [4:0]         nbr_reg;
  neighbor_t          neighbor_q [$];

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 46;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] weighted_dist(int unsigned pt, int unsigned nd);
    logic [63:0] acc;
    longint      diff;
    longint      mag;
    acc = 0;
    for (int l = 0; l < nd; l++) begin
      diff = longint'(ref_coord[pt][l]) - longint'(query_coord[l]);
      mag = (diff < 0) ? -diff : diff;
      acc = acc + 64'(mag) * 64'(mag) * 64'(dim_weight[l]);
    end
    acc = acc >> 8;
    return (acc > 64'(knn_pkg::DIST_MAX)) ? knn_pkg::DIST_MAX : acc[47:0];
  endfunction

  // Keeps the k smallest distances; strict compare leaves ties in index order.
  task automatic predict_neighbors();
    int unsigned np, nd, k, cnt, pos;
    logic [47:0] best_d [NNBR];
    logic [9:0]  best_i [NNBR];
    logic [47:0] d;
    neighbor_t   nb;
    np = clamp_reg(point_reg, NPTS);
    nd = clamp_reg(dim_reg, NDIMS);
    k = clamp_reg(nbr_reg, NNBR);
    if (k > np) k = np;
    cnt = 0;
    for (int i = 0; i < np; i++) begin
      d = weighted_dist(i, nd);
      pos = cnt;
      while (pos > 0 && d < best_d[pos-1]) pos--;
      if (pos < k) begin
        for (int t = ((cnt < k) ? cnt : k - 1); t > pos; t--) begin
          best_d[t] = best_d[t-1];
          best_i[t] = best_i[t-1];
        end
        best_d[pos] = d;
        best_i[pos] = 10'(i);
        if (cnt < k) cnt++;
      end
    end
    for (int t = 0; t < k; t++) begin
      nb.rank = 4'(t);
      nb.index = best_i[t];
      nb.root_dist = 24'(floor_sqrt(64'(best_d[t])));
      nb.last = (t + 1 == k);
      neighbor_q.push_back(nb);
    end
  endtask

  always @(posedge clk) begin
    neighbor_t exp_nb;
    if (!rst_n) begin
      point_reg <= 11'd1024;
      dim_reg <= 5'd16;
      nbr_reg <= 5'd1;
      neighbor_q.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          knn_pkg::CFG_POINT_COUNT:    point_reg <= cfg_data[10:0];
          knn_pkg::CFG_DIM_COUNT:      dim_reg <= cfg_data[4:0];
          knn_pkg::CFG_NEIGHBOR_COUNT: nbr_reg <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_operation)
          knn_pkg::OP_LOAD_WEIGHT: dim_weight[in_dim_index] = in_weight_value;
          knn_pkg::OP_LOAD_REF:    ref_coord[in_point_index][in_dim_index] = in_coord_value;
          knn_pkg::OP_QUERY: begin
            query_coord[in_dim_index] = in_coord_value;
            if (in_dim_index == 4'(clamp_reg(dim_reg, NDIMS) - 1)) predict_neighbors();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (neighbor_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result rank %0d index %0d distance %0d last %0b",
                     $realtime, out_rank, out_neighbor_index, out_distance, out_last);
          fail_count <= fail_count + 1;
        end else begin
          exp_nb = neighbor_q.pop_front();
          if (exp_nb.rank !== out_rank || exp_nb.index !== out_neighbor_index ||
              exp_nb.root_dist !== out_distance || exp_nb.last !== out_last) begin
            if (fail_count < 10) begin
              $display("[%0t] mismatch: expected rank %0d index %0d distance %0d last %0b",
                       $realtime, exp_nb.rank, exp_nb.index, exp_nb.root_dist, exp_nb.last);
              $display("    got rank %0d index %0d distance %0d last %0b",
                       out_rank, out_neighbor_index, out_distance, out_last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= neighbor_q.size();
    end
  end
endmodule

// ===== test/tb_knn_search_weighted_euclid.sv =====
// Stimulus, flow control and verdict for the weighted Euclidean k-NN search block.
`timescale 1ns / 1ps
module tb_knn_search_weighted_euclid;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 100000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = OP_UNUSED;
  logic [9:0]         in_point_index = '0;
  logic [3:0]         in_dim_index = '0;
  logic signed [15:0] in_coord_value = '0;
  logic [15:0]        in_weight_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_rank;
  logic [9:0]         out_neighbor_index;
  logic [23:0]        out_distance;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 hold_req = 0;
  bit                 hold_taken = 0;
  int                 cur_dims = 1;

  knn_search_weighted_euclid u_top (.*);

  knn_result_checker u_checker (.*);

  initial forever #1 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver flow control; one long hold-off is taken when requested.
  initial begin
    int len;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        out_stall <= 1'b1;
        len = 1500;
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall <= 1'b0;
        len = $urandom_range(50, 150);
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 4)) - 2);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [1:0] op, logic [9:0] pidx, logic [3:0] didx,
                      logic [15:0] coord, logic [15:0] wval);
    int gap;
    gap = $urandom_range(0, 99);
    gap = (gap < 60) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_point_index <= pidx;
    in_dim_index <= didx;
    in_coord_value <= coord;
    in_weight_value <= wval;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every expected transaction has left, plus the load pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] pts, logic [15:0] dims, logic [15:0] nbrs);
    cfg_write(knn_pkg::CFG_POINT_COUNT, pts);
    cfg_write(knn_pkg::CFG_DIM_COUNT, dims);
    cfg_write(knn_pkg::CFG_NEIGHBOR_COUNT, nbrs);
    cur_dims = (dims[4:0] == 0) ? 1 : (dims[4:0] > 16) ? 16 : dims[4:0];
  endtask

  task automatic send_query();
    for (int l = 0; l < cur_dims; l++)
      send(knn_pkg::OP_QUERY, 10'($urandom), 4'(l), rand_coord(), 16'($urandom));
  endtask

  initial begin
    int r;
    int pt;
    int dm;
    int deff;
    int pmax;
    @(posedge rst_n);
    @(posedge clk);
    configure(16'd0, 16'd0, 16'd0);

    // Every weight; points 0 to 3 in dimensions 0 to 3 and points 0 and 1 in all dimensions.
    send(knn_pkg::OP_LOAD_WEIGHT, 10'd0, 4'd0, 16'h0000, 16'hffff);
    send(knn_pkg::OP_LOAD_WEIGHT, 10'd0, 4'd1, 16'h0000, 16'h0000);
    send(knn_pkg::OP_LOAD_WEIGHT, 10'd0, 4'd2, 16'h0000, 16'h0100);
    for (int l = 3; l < 16; l++) send(knn_pkg::OP_LOAD_WEIGHT, 10'($urandom), 4'(l),
                                      16'($urandom), 16'($urandom));
    for (int p = 0; p < 4; p++)
      for (int l = 0; l < 16; l++)
        if (p < 2 || l < 4)
          send(knn_pkg::OP_LOAD_REF, 10'(p), 4'(l),
               (p == 0) ? 16'h8000 : (p == 1) ? 16'h7fff : 16'h0001, 16'($urandom));
    send(OP_UNUSED, 10'h3ff, 4'hf, 16'hffff, 16'hffff);
    send(knn_pkg::OP_QUERY, 10'd0, 4'd0, 16'h7fff, 16'd0);
    settle();

    // Dimension and neighbor counts above their range, more neighbors than points.
    configure(16'd2, 16'd31, 16'd31);
    for (int l = 0; l < 16; l++) send(knn_pkg::OP_QUERY, 10'd0, 4'(l), 16'h8000, 16'd0);
    settle();

    // Two points at equal distance, and a query coordinate that does not trigger.
    configure(16'd4, 16'd4, 16'd3);
    for (int l = 0; l < 3; l++) send(knn_pkg::OP_QUERY, 10'd0, 4'(l), 16'h0001, 16'd0);
    send(knn_pkg::OP_QUERY, 10'd0, 4'd9, 16'h1234, 16'd0);
    send(knn_pkg::OP_QUERY, 10'd0, 4'd3, 16'hffff, 16'd0);
    settle();

    // The receiver holds off for a long stretch while a query is in flight.
    configure(16'd4, 16'd4, 16'd4);
    hold_req = 1;
    wait (hold_taken);
    send_query();
    for (int ph = 0; ph < 2; ph++) begin
      for (int n = 0; n < 6; n++) begin
        r = $urandom_range(0, 9);
        if (r < 4) send_query();
        else if (r < 7) begin
          pt = $urandom_range(0, 3);
          dm = (pt < 2) ? $urandom_range(0, 15) : $urandom_range(0, 3);
          send(knn_pkg::OP_LOAD_REF, 10'(pt), 4'(dm), rand_coord(), 16'($urandom));
        end
        else if (r < 8)
          send(knn_pkg::OP_LOAD_WEIGHT, 10'($urandom), 4'($urandom), 16'($urandom),
               $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3) << 8));
        else if (r < 9)
          send(knn_pkg::OP_QUERY, 10'($urandom), 4'($urandom), rand_coord(),
               16'($urandom));
        else
          send(OP_UNUSED, 10'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      end
      settle();
      // Only points 0 and 1 are loaded beyond dimension 3.
      deff = $urandom_range(0, 31);
      pmax = (deff > 4) ? 2 : 4;
      configure(16'($urandom_range(0, pmax)), 16'(deff), 16'($urandom_range(0, 31)));
    end
    send_query();
    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
